// ===== hw/rtl/betweenness_centrality_engine_defines.svh =====
// Assertion macros for the betweenness centrality RTL.
`ifndef BETWEENNESS_CENTRALITY_ENGINE_DEFINES_SVH
`define BETWEENNESS_CENTRALITY_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked by clk, off while arst_n is low.
`define BC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked by clk, off while arst_n is low.
`define BC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bc_pkg.sv =====
// Shared types and constants for the betweenness centrality engine.
package bc_pkg;

	localparam int unsigned MAX_NODES_DEF = 256;
	localparam int unsigned MAX_EDGES_DEF = 2048;

	localparam int unsigned VAL_W = 48;
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_ONE = 48'h0000_0001_0000; // 1.0 in Q32.16

	typedef enum logic [1:0] {
		ACT_ADD_EDGE = 2'd0,
		ACT_COMPUTE  = 2'd1,
		ACT_READ     = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_BAD_NODE = 2'd2
	} status_t;

	// request to the multiply-divide unit: floor(mult_a * mult_b / divisor)
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] mult_a;
		logic [VAL_W:0]   mult_b;
		logic [VAL_W-1:0] divisor;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quot;
	} md_rsp_t;

endpackage

// ===== hw/rtl/betweenness_centrality_engine.sv =====
// Top level: Brandes betweenness centrality over a stored undirected edge list.
//
// Usage:
//  - Slave stream: s_tuser carries the action (add edge, compute, read, clear edges),
//    s_tdata the two node indexes. Every accepted transaction yields exactly one
//    master-stream transaction: status, Q32.16 centrality and the overflow flag.
//  - cfg_we/cfg_wdata set node_count; write it only while the block is idle.
//  - One transaction at a time: s_tready is high only while the sequencer is idle.
//    Add, clear and rejected reads pass straight to EMIT and the output register;
//    a good read first waits in RD_WAIT for one centrality memory read.
//  - Compute is a long walk: it clears the centrality memory, then per source
//    initialises the scratch entries of the n nodes, runs a BFS that scans every
//    stored edge for each visited node, and a reverse pass with the same edge scans
//    plus one request per dependency term to the shared multiply-divide unit.
//  - The result sits in an output register; the sequencer takes the next
//    transaction while it waits, and holds a new result until m_tready frees it.
//  - After reset the centrality memory is swept to zero, one entry a cycle,
//    with s_tready low; cfg writes are taken meanwhile.
module betweenness_centrality_engine import bc_pkg::*; #(
	parameter int unsigned MAX_NODES = MAX_NODES_DEF,
	parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,    // node_count
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // [7:0] first_node, [15:8] second_node
	input  logic [1:0]  s_tuser,      // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata       // [1:0] status, [49:2] centrality, [50] count_overflow
);

	`include "betweenness_centrality_engine_defines.svh"

	localparam int unsigned IW  = $clog2(MAX_NODES);          // node address
	localparam int unsigned CW  = $clog2(MAX_NODES + 1);      // node counters
	localparam int unsigned DW  = IW + 1;                     // hop distance
	localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EW  = $clog2(MAX_EDGES + 1);      // edge counters
	localparam logic [DW-1:0] UNREACHED = {DW{1'b1}};

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_SRC_INIT, ST_SRC_SEED,
		ST_POP, ST_POP_U, ST_POP_D, ST_E_RD, ST_E_CHK, ST_F_UPD,
		ST_BK_NEXT, ST_BK_W, ST_BK_WD, ST_B_ERD, ST_B_CHK, ST_B_VD, ST_B_MD,
		ST_BK_CENT_RD, ST_BK_CENT_WR, ST_SRC_DONE, ST_RD_WAIT, ST_EMIT
	} state_t;

	// saturating 48-bit add; top bit flags saturation
	function automatic logic [VAL_W:0] add_sat(input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] y);
		logic [VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[VAL_W] ? {1'b1, VAL_MAX} : s;
	endfunction

	// ---------------- sequencer registers ----------------
	state_t           state_q;
	logic             boot_q;
	logic [8:0]       node_count_q;
	logic [EW-1:0]    edges_q;
	logic [EW-1:0]    eidx_q;
	logic             k_q;          // which end of the edge is matched
	logic [CW-1:0]    src_q;
	logic [CW-1:0]    idx_q;        // sweep index, reverse-walk index
	logic [CW-1:0]    head_q;
	logic [CW-1:0]    tail_q;
	logic [IW-1:0]    u_q;
	logic [DW-1:0]    du_q;
	logic [VAL_W-1:0] su_q;
	logic [IW-1:0]    w_q;
	logic [DW-1:0]    dw_q;
	logic [VAL_W-1:0] sw_q;
	logic [VAL_W-1:0] delw_q;
	logic [IW-1:0]    v_q;
	logic [VAL_W-1:0] delv_q;
	logic             sat_q;
	logic             ovf_q;
	status_t          res_status_q;
	logic [VAL_W-1:0] res_cent_q;
	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;

	// ---------------- memories ----------------
	logic [15:0]      edge_mem [MAX_EDGES];   // {second, first}
	logic [DW-1:0]    dist_mem [MAX_NODES];
	logic [VAL_W-1:0] sig_mem  [MAX_NODES];
	logic [VAL_W-1:0] del_mem  [MAX_NODES];
	logic [IW-1:0]    ord_mem  [MAX_NODES];
	logic [VAL_W-1:0] cent_mem [MAX_NODES];

	logic             e_we, e_re;
	logic [EAW-1:0]   e_wa, e_ra;
	logic [15:0]      e_wd, e_rd_q;
	logic             d_we, d_re;
	logic [IW-1:0]    d_wa, d_ra;
	logic [DW-1:0]    d_wd, d_rd_q;
	logic             g_we, g_re;
	logic [IW-1:0]    g_wa, g_ra;
	logic [VAL_W-1:0] g_wd, g_rd_q;
	logic             l_we, l_re;
	logic [IW-1:0]    l_wa, l_ra;
	logic [VAL_W-1:0] l_wd, l_rd_q;
	logic             o_we, o_re;
	logic [IW-1:0]    o_wa, o_ra, o_wd, o_rd_q;
	logic             c_we, c_re;
	logic [IW-1:0]    c_wa, c_ra;
	logic [VAL_W-1:0] c_wd, c_rd_q;

	always_ff @(posedge clk) begin
		if (e_we) edge_mem[e_wa] <= e_wd;
		if (e_re) e_rd_q <= edge_mem[e_ra];
	end
	always_ff @(posedge clk) begin
		if (d_we) dist_mem[d_wa] <= d_wd;
		if (d_re) d_rd_q <= dist_mem[d_ra];
	end
	always_ff @(posedge clk) begin
		if (g_we) sig_mem[g_wa] <= g_wd;
		if (g_re) g_rd_q <= sig_mem[g_ra];
	end
	always_ff @(posedge clk) begin
		if (l_we) del_mem[l_wa] <= l_wd;
		if (l_re) l_rd_q <= del_mem[l_ra];
	end
	always_ff @(posedge clk) begin
		if (o_we) ord_mem[o_wa] <= o_wd;
		if (o_re) o_rd_q <= ord_mem[o_ra];
	end
	always_ff @(posedge clk) begin
		if (c_we) cent_mem[c_wa] <= c_wd;
		if (c_re) c_rd_q <= cent_mem[c_ra];
	end

	// ---------------- datapath decode ----------------
	action_t          action;
	logic [7:0]       first_node, second_node;
	logic             s_acc;
	logic [31:0]      n32;          // active node count, clamped to 1..MAX_NODES
	logic             p_bad, q_bad, store_full;
	logic [7:0]       ea, eb;
	logic [IW-1:0]    ctr, v_sel;
	logic             hit;
	logic [DW-1:0]    du1, dvn;
	logic             is_new, upd, bwd_ok;
	logic [VAL_W:0]   sig_sum, del_sum, cent_sum;
	md_req_t          md_req;
	md_rsp_t          md_rsp;

	assign action      = action_t'(s_tuser);
	assign first_node  = s_tdata[7:0];
	assign second_node = s_tdata[15:8];
	assign s_tready    = (state_q == ST_IDLE);
	assign s_acc       = s_tvalid && s_tready;

	always_comb begin
		if (node_count_q == '0)
			n32 = 32'd1;
		else if (32'(node_count_q) > 32'(MAX_NODES))
			n32 = 32'(MAX_NODES);
		else
			n32 = 32'(node_count_q);
	end

	assign p_bad      = 32'(first_node) >= n32;
	assign q_bad      = 32'(second_node) >= n32;
	assign store_full = 32'(edges_q) >= 32'(MAX_EDGES);

	// neighbor check on the edge just read; edges with a dead endpoint drop out
	assign ea    = e_rd_q[7:0];
	assign eb    = e_rd_q[15:8];
	assign ctr   = (state_q == ST_B_CHK) ? w_q : u_q;
	assign v_sel = k_q ? IW'(ea) : IW'(eb);
	assign hit   = (32'(ea) < n32) && (32'(eb) < n32) &&
		(k_q ? (32'(eb) == 32'(ctr)) : (32'(ea) == 32'(ctr)));

	// forward relax
	assign du1     = du_q + DW'(1);
	assign is_new  = (d_rd_q == UNREACHED) && (32'(tail_q) < 32'(MAX_NODES));
	assign dvn     = is_new ? du1 : d_rd_q;
	assign upd     = (dvn == du1);
	assign sig_sum = add_sat(g_rd_q, su_q);

	// reverse pass: v is a predecessor of w
	assign bwd_ok   = (d_rd_q != UNREACHED) && ((d_rd_q + DW'(1)) == dw_q);
	assign del_sum  = add_sat(delv_q, md_rsp.quot);
	assign cent_sum = add_sat(c_rd_q, delw_q);

	assign md_req.start   = (state_q == ST_B_VD) && bwd_ok;
	assign md_req.mult_a  = g_rd_q;
	assign md_req.mult_b  = (VAL_W+1)'(VAL_ONE) + (VAL_W+1)'(delw_q);
	assign md_req.divisor = sw_q;

	bc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// memory port control
	always_comb begin
		e_we = 1'b0; e_re = 1'b0; e_wa = '0; e_ra = '0; e_wd = '0;
		d_we = 1'b0; d_re = 1'b0; d_wa = '0; d_ra = '0; d_wd = '0;
		g_we = 1'b0; g_re = 1'b0; g_wa = '0; g_ra = '0; g_wd = '0;
		l_we = 1'b0; l_re = 1'b0; l_wa = '0; l_ra = '0; l_wd = '0;
		o_we = 1'b0; o_re = 1'b0; o_wa = '0; o_ra = '0; o_wd = '0;
		c_we = 1'b0; c_re = 1'b0; c_wa = '0; c_ra = '0; c_wd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && action == ACT_ADD_EDGE && !p_bad && !q_bad && !store_full) begin
					e_we = 1'b1;
					e_wa = EAW'(edges_q);
					e_wd = {second_node, first_node};
				end
				if (s_acc && action == ACT_READ && !p_bad) begin
					c_re = 1'b1;
					c_ra = IW'(first_node);
				end
			end
			ST_CLR: begin
				c_we = 1'b1;
				c_wa = IW'(idx_q);
			end
			ST_SRC_INIT: begin
				d_we = 1'b1; d_wa = IW'(idx_q); d_wd = UNREACHED;
				g_we = 1'b1; g_wa = IW'(idx_q);
				l_we = 1'b1; l_wa = IW'(idx_q);
			end
			ST_SRC_SEED: begin
				d_we = 1'b1; d_wa = IW'(src_q);
				g_we = 1'b1; g_wa = IW'(src_q); g_wd = VAL_W'(1);
				o_we = 1'b1; o_wd = IW'(src_q);
			end
			ST_POP: begin
				o_re = (head_q < tail_q);
				o_ra = IW'(head_q);
			end
			ST_POP_U: begin
				d_re = 1'b1; d_ra = o_rd_q;
				g_re = 1'b1; g_ra = o_rd_q;
			end
			ST_E_RD, ST_B_ERD: begin
				e_re = (eidx_q < edges_q);
				e_ra = EAW'(eidx_q);
			end
			ST_E_CHK: begin
				d_re = hit; d_ra = v_sel;
				g_re = hit; g_ra = v_sel;
			end
			ST_F_UPD: begin
				o_we = is_new; o_wa = IW'(tail_q); o_wd = v_q;
				d_we = is_new; d_wa = v_q; d_wd = du1;
				g_we = upd; g_wa = v_q; g_wd = sig_sum[VAL_W-1:0];
			end
			ST_BK_NEXT: begin
				o_re = (idx_q != '0);
				o_ra = IW'(idx_q - CW'(1));
			end
			ST_BK_W: begin
				d_re = 1'b1; d_ra = o_rd_q;
				g_re = 1'b1; g_ra = o_rd_q;
				l_re = 1'b1; l_ra = o_rd_q;
			end
			ST_B_CHK: begin
				d_re = hit; d_ra = v_sel;
				g_re = hit; g_ra = v_sel;
				l_re = hit; l_ra = v_sel;
			end
			ST_B_MD: begin
				l_we = md_rsp.done; l_wa = v_q; l_wd = del_sum[VAL_W-1:0];
			end
			ST_BK_CENT_RD: begin
				c_re = (32'(w_q) != 32'(src_q));
				c_ra = w_q;
			end
			ST_BK_CENT_WR: begin
				c_we = 1'b1; c_wa = w_q; c_wd = cent_sum[VAL_W-1:0];
			end
			default: ;
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			boot_q       <= 1'b1;
			node_count_q <= 9'd1;
			edges_q      <= '0;
			eidx_q       <= '0;
			k_q          <= 1'b0;
			src_q        <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			sat_q        <= 1'b0;
			ovf_q        <= 1'b0;
			res_status_q <= STS_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				node_count_q <= cfg_wdata;
			// EMIT reloads the output register itself when it frees up
			if (m_tvalid_q && m_tready && state_q != ST_EMIT)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						res_cent_q <= '0;
						case (action)
							ACT_ADD_EDGE: begin
								if (p_bad || q_bad) begin
									res_status_q <= STS_BAD_NODE;
								end else if (store_full) begin
									res_status_q <= STS_FULL;
								end else begin
									res_status_q <= STS_OK;
									edges_q      <= edges_q + EW'(1);
								end
								state_q <= ST_EMIT;
							end
							ACT_COMPUTE: begin
								sat_q   <= 1'b0;
								idx_q   <= '0;
								state_q <= ST_CLR;
							end
							ACT_READ: begin
								if (p_bad) begin
									res_status_q <= STS_BAD_NODE;
									state_q      <= ST_EMIT;
								end else begin
									res_status_q <= STS_OK;
									state_q      <= ST_RD_WAIT;
								end
							end
							ACT_CLEAR: begin
								res_status_q <= STS_OK;
								edges_q      <= '0;
								state_q      <= ST_EMIT;
							end
							default: begin
								res_status_q <= STS_OK;
								state_q      <= ST_EMIT;
							end
						endcase
					end
				end
				ST_CLR: begin
					if (idx_q == CW'(MAX_NODES - 1)) begin
						idx_q <= '0;
						src_q <= '0;
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SRC_INIT;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_SRC_INIT: begin
					if (32'(idx_q) == n32 - 32'd1)
						state_q <= ST_SRC_SEED;
					else
						idx_q <= idx_q + CW'(1);
				end
				ST_SRC_SEED: begin
					head_q  <= '0;
					tail_q  <= CW'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (head_q < tail_q) begin
						state_q <= ST_POP_U;
					end else begin
						idx_q   <= tail_q;
						state_q <= ST_BK_NEXT;
					end
				end
				ST_POP_U: begin
					u_q     <= o_rd_q;
					head_q  <= head_q + CW'(1);
					state_q <= ST_POP_D;
				end
				ST_POP_D: begin
					du_q    <= d_rd_q;
					su_q    <= g_rd_q;
					eidx_q  <= '0;
					k_q     <= 1'b0;
					state_q <= ST_E_RD;
				end
				ST_E_RD: begin
					state_q <= (eidx_q < edges_q) ? ST_E_CHK : ST_POP;
				end
				ST_E_CHK: begin
					if (hit) begin
						v_q     <= v_sel;
						state_q <= ST_F_UPD;
					end else if (!k_q) begin
						k_q <= 1'b1;
					end else begin
						k_q     <= 1'b0;
						eidx_q  <= eidx_q + EW'(1);
						state_q <= ST_E_RD;
					end
				end
				ST_F_UPD: begin
					if (is_new)
						tail_q <= tail_q + CW'(1);
					if (upd && sig_sum[VAL_W])
						sat_q <= 1'b1;
					if (!k_q) begin
						k_q     <= 1'b1;
						state_q <= ST_E_CHK;
					end else begin
						k_q     <= 1'b0;
						eidx_q  <= eidx_q + EW'(1);
						state_q <= ST_E_RD;
					end
				end
				// reverse visit order
				ST_BK_NEXT: begin
					state_q <= (idx_q != '0) ? ST_BK_W : ST_SRC_DONE;
				end
				ST_BK_W: begin
					w_q     <= o_rd_q;
					state_q <= ST_BK_WD;
				end
				ST_BK_WD: begin
					dw_q   <= d_rd_q;
					sw_q   <= g_rd_q;
					delw_q <= l_rd_q;
					eidx_q <= '0;
					k_q    <= 1'b0;
					state_q <= (d_rd_q != '0) ? ST_B_ERD : ST_BK_CENT_RD;
				end
				ST_B_ERD: begin
					state_q <= (eidx_q < edges_q) ? ST_B_CHK : ST_BK_CENT_RD;
				end
				ST_B_CHK: begin
					if (hit) begin
						v_q     <= v_sel;
						state_q <= ST_B_VD;
					end else if (!k_q) begin
						k_q <= 1'b1;
					end else begin
						k_q     <= 1'b0;
						eidx_q  <= eidx_q + EW'(1);
						state_q <= ST_B_ERD;
					end
				end
				ST_B_VD: begin
					if (bwd_ok) begin
						delv_q  <= l_rd_q;
						state_q <= ST_B_MD;
					end else if (!k_q) begin
						k_q     <= 1'b1;
						state_q <= ST_B_CHK;
					end else begin
						k_q     <= 1'b0;
						eidx_q  <= eidx_q + EW'(1);
						state_q <= ST_B_ERD;
					end
				end
				ST_B_MD: begin
					if (md_rsp.done) begin
						if (!k_q) begin
							k_q     <= 1'b1;
							state_q <= ST_B_CHK;
						end else begin
							k_q     <= 1'b0;
							eidx_q  <= eidx_q + EW'(1);
							state_q <= ST_B_ERD;
						end
					end
				end
				ST_BK_CENT_RD: begin
					if (32'(w_q) != 32'(src_q)) begin
						state_q <= ST_BK_CENT_WR;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= ST_BK_NEXT;
					end
				end
				ST_BK_CENT_WR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= ST_BK_NEXT;
				end
				ST_SRC_DONE: begin
					if (32'(src_q) + 32'd1 == n32) begin
						ovf_q        <= sat_q;
						res_status_q <= STS_OK;
						res_cent_q   <= '0;
						state_q      <= ST_EMIT;
					end else begin
						src_q   <= src_q + CW'(1);
						idx_q   <= '0;
						state_q <= ST_SRC_INIT;
					end
				end
				ST_RD_WAIT: begin
					res_cent_q <= c_rd_q;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b0, ovf_q, res_cent_q, res_status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------- checks ----------------
	`BC_ASSERT_NOW(a_edge_bound, 1'b1, 32'(edges_q) <= 32'(MAX_EDGES), "edge count past capacity")
	`BC_ASSERT_NOW(a_queue_order, 1'b1, head_q <= tail_q, "BFS head passed tail")
	`BC_ASSERT_NOW(a_md_owner, md_rsp.done, state_q == ST_B_MD, "divide result with no taker")
	`BC_ASSERT_NEXT(a_compute_clr, s_acc && (action == ACT_COMPUTE), state_q == ST_CLR, "compute did not start with a clear")

endmodule

// ===== hw/rtl/bc_muldiv.sv =====
// Bit-serial multiply then restoring divide on one shared adder, result saturated to 48 bits, zero for a zero divisor.
module bc_muldiv import bc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam int unsigned PW = 2 * VAL_W + 1;   // product width
	localparam logic [6:0] MUL_LAST = 7'(VAL_W);  // multiplier has VAL_W+1 bits
	localparam logic [6:0] DIV_LAST = 7'(PW - 1);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	md_state_t        st_q;
	logic [6:0]       cnt_q;
	logic [VAL_W-1:0] a_q;
	logic [VAL_W:0]   b_q;
	logic [VAL_W-1:0] d_q;
	logic [PW-1:0]    acc_q;
	logic [VAL_W-1:0] r_q;
	logic [VAL_W-1:0] q_q;
	logic             big_q;
	logic             done_q;
	logic [VAL_W-1:0] res_q;

	logic [VAL_W:0]   r_next;
	logic [PW:0]      add_x, add_y, add_s;
	logic             add_cin;
	logic             geq;
	logic [VAL_W-1:0] q_fin;
	logic             big_fin;

	assign r_next = {r_q, acc_q[PW-1]};

	// the one adder: accumulate in MUL, trial subtract in DIV
	always_comb begin
		if (st_q == MD_DIV) begin
			add_x   = (PW+1)'(r_next);
			add_y   = ~((PW+1)'(d_q));
			add_cin = 1'b1;
		end else begin
			add_x   = {1'b0, acc_q[PW-2:0], 1'b0};
			add_y   = (PW+1)'(b_q[VAL_W] ? a_q : '0);
			add_cin = 1'b0;
		end
		add_s = add_x + add_y + (PW+1)'(add_cin);
	end

	assign geq     = !add_s[PW];
	assign q_fin   = {q_q[VAL_W-2:0], geq};
	assign big_fin = big_q | q_q[VAL_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MD_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				MD_IDLE: begin
					if (req.start) begin
						a_q   <= req.mult_a;
						b_q   <= req.mult_b;
						d_q   <= req.divisor;
						acc_q <= '0;
						cnt_q <= '0;
						st_q  <= MD_MUL;
					end
				end
				MD_MUL: begin
					acc_q <= add_s[PW-1:0];
					b_q   <= {b_q[VAL_W-1:0], 1'b0};
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						r_q   <= '0;
						q_q   <= '0;
						big_q <= 1'b0;
						st_q  <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				MD_DIV: begin
					acc_q <= {acc_q[PW-2:0], 1'b0};
					r_q   <= geq ? add_s[VAL_W-1:0] : r_next[VAL_W-1:0];
					q_q   <= q_fin;
					big_q <= big_fin;
					if (cnt_q == DIV_LAST) begin
						done_q <= 1'b1;
						if (d_q == '0)
							res_q <= '0;
						else
							res_q <= big_fin ? VAL_MAX : q_fin;
						st_q <= MD_IDLE;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: st_q <= MD_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

endmodule
